>>> src/mip_level_box_downsample_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mip level box downsampler
// Shorthand for clocked implications with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef MIP_LEVEL_BOX_DOWNSAMPLE_TOP_ASSERT_SVH
`define MIP_LEVEL_BOX_DOWNSAMPLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define MLBD_ASSERT_IMP(name, clock, rstn, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication.
`define MLBD_ASSERT_NXT(name, clock, rstn, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

>>> src/mlbd_pkg.sv
// ----------------------------------------------------------------------------
// mlbd_pkg
// Shared types, widths and register codes of the mip level box downsampler.
// ----------------------------------------------------------------------------
package mlbd_pkg;

	localparam int MAX_WIDTH_DEF = 4096;

	localparam int CHAN_W   = 8;
	localparam int NUM_CHAN = 4;
	localparam int PAIR_W   = CHAN_W + 1;
	localparam int SUM_W    = PAIR_W + 1;
	localparam int LINE_W   = NUM_CHAN * PAIR_W;

	localparam int WIDTH_REG_W  = 13;
	localparam int HEIGHT_W     = 16;
	localparam int CHAN_CNT_W   = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

	typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pix_t;
	typedef logic [NUM_CHAN-1:0][PAIR_W-1:0] pair_t;
	typedef logic [NUM_CHAN-1:0][SUM_W-1:0]  sum_t;

	typedef struct packed {
		logic [WIDTH_REG_W-1:0] w_last;
		logic [WIDTH_REG_W-2:0] ow_last;
		logic                   w_one;
		logic [HEIGHT_W-1:0]    h_last;
		logic [HEIGHT_W-2:0]    oh_last;
		logic                   h_one;
		logic [CHAN_CNT_W-1:0]  chan_cnt;
	} geom_t;

	typedef struct packed {
		logic rd;
		logic last;
	} ctl_t;

endpackage

>>> src/mlbd_if.sv
// ----------------------------------------------------------------------------
// mlbd_if
// Valid/ready channels for source pixels and destination pixels.
// ----------------------------------------------------------------------------
interface mlbd_pix_if;
	import mlbd_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] chan_a;
	logic [CHAN_W-1:0] chan_b;
	logic [CHAN_W-1:0] chan_c;
	logic [CHAN_W-1:0] chan_d;

	modport source (output valid, chan_a, chan_b, chan_c, chan_d, input ready);
	modport sink (input valid, chan_a, chan_b, chan_c, chan_d, output ready);
endinterface

interface mlbd_res_if;
	import mlbd_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] out_a;
	logic [CHAN_W-1:0] out_b;
	logic [CHAN_W-1:0] out_c;
	logic [CHAN_W-1:0] out_d;
	logic              level_done;

	modport source (output valid, out_a, out_b, out_c, out_d, level_done, input ready);
	modport sink (input valid, out_a, out_b, out_c, out_d, level_done, output ready);
endinterface

>>> src/mlbd_ram.sv
// ----------------------------------------------------------------------------
// mlbd_ram
// Generic two-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mlbd_ram #(
	parameter int DATA_W = mlbd_pkg::LINE_W,
	parameter int DEPTH = mlbd_pkg::MAX_WIDTH_DEF / 2,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);
	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

>>> src/mlbd_cfg.sv
// ----------------------------------------------------------------------------
// mlbd_cfg
// Configuration registers, kept in the normalised form the datapath uses.
// ----------------------------------------------------------------------------
module mlbd_cfg #(
	parameter int MAX_WIDTH = mlbd_pkg::MAX_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mlbd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mlbd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output mlbd_pkg::geom_t                  geom,
	output logic                             restart
);
	import mlbd_pkg::*;

	geom_t                  geom_q;
	logic [WIDTH_REG_W-1:0] w_raw, w_eff, ow, ow_m1;
	logic [HEIGHT_W-1:0]    h_raw, h_eff, oh, oh_m1;
	logic [CHAN_CNT_W-1:0]  c_raw, c_eff;

	always_comb begin
		w_raw = cfg_data[WIDTH_REG_W-1:0];
		w_eff = (w_raw == '0) ? WIDTH_REG_W'(1) : w_raw;
		if (32'(w_eff) > MAX_WIDTH) begin
			w_eff = WIDTH_REG_W'(MAX_WIDTH);
		end
		ow    = ((w_eff >> 1) == '0) ? WIDTH_REG_W'(1) : (w_eff >> 1);
		ow_m1 = ow - 1'b1;

		h_raw = cfg_data[HEIGHT_W-1:0];
		h_eff = (h_raw == '0) ? HEIGHT_W'(1) : h_raw;
		oh    = ((h_eff >> 1) == '0) ? HEIGHT_W'(1) : (h_eff >> 1);
		oh_m1 = oh - 1'b1;

		c_raw = cfg_data[CHAN_CNT_W-1:0];
		if (c_raw == '0) begin
			c_eff = CHAN_CNT_W'(1);
		end else if (c_raw > CHAN_CNT_W'(NUM_CHAN)) begin
			c_eff = CHAN_CNT_W'(NUM_CHAN);
		end else begin
			c_eff = c_raw;
		end
	end

	always_comb begin
		restart = cfg_we && (cfg_index == CFG_SOURCE_WIDTH ||
			cfg_index == CFG_SOURCE_HEIGHT || cfg_index == CFG_CHANNEL_COUNT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.w_last   <= '0;
			geom_q.ow_last  <= '0;
			geom_q.w_one    <= 1'b1;
			geom_q.h_last   <= '0;
			geom_q.oh_last  <= '0;
			geom_q.h_one    <= 1'b1;
			geom_q.chan_cnt <= CHAN_CNT_W'(NUM_CHAN);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SOURCE_WIDTH: begin
					geom_q.w_last  <= w_eff - 1'b1;
					geom_q.ow_last <= ow_m1[WIDTH_REG_W-2:0];
					geom_q.w_one   <= (w_eff == WIDTH_REG_W'(1));
				end
				CFG_SOURCE_HEIGHT: begin
					geom_q.h_last  <= h_eff - 1'b1;
					geom_q.oh_last <= oh_m1[HEIGHT_W-2:0];
					geom_q.h_one   <= (h_eff == HEIGHT_W'(1));
				end
				CFG_CHANNEL_COUNT: begin
					geom_q.chan_cnt <= c_eff;
				end
				default: begin
				end
			endcase
		end
	end

	assign geom = geom_q;
endmodule

>>> src/mlbd_front.sv
// ----------------------------------------------------------------------------
// mlbd_front
// Raster position, horizontal pairing and line store addressing.
// ----------------------------------------------------------------------------
module mlbd_front #(
	parameter int MAX_WIDTH = mlbd_pkg::MAX_WIDTH_DEF,
	localparam int LINE_DEPTH = MAX_WIDTH / 2,
	localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mlbd_pkg::geom_t     geom,
	input  logic                restart,
	input  logic                accept,
	input  mlbd_pkg::pix_t      pix,
	input  logic                ready_s1,
	output logic                ram_wr_en,
	output logic                ram_rd_en,
	output logic [ADDR_W-1:0]   ram_addr,
	output mlbd_pkg::pair_t     ram_wr_data,
	output logic                valid_s1,
	output mlbd_pkg::ctl_t      ctl_s1,
	output mlbd_pkg::pair_t     pair_s1
);
	import mlbd_pkg::*;

	localparam int COL_LOG = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int COL_W = (COL_LOG > WIDTH_REG_W) ? WIDTH_REG_W : COL_LOG;

	logic [COL_W-1:0]       col_q;
	logic [HEIGHT_W-1:0]    row_q;
	pix_t                   held_q;

	logic [WIDTH_REG_W-1:0] ox;
	pair_t                  pair;
	logic                   have_pair, col_last, row_last;
	logic                   wr_now, rd_now, emit_now, last_now;

	always_comb begin
		ox       = WIDTH_REG_W'(col_q >> 1);
		col_last = (WIDTH_REG_W'(col_q) == geom.w_last);
		row_last = (row_q == geom.h_last);
		for (int i = 0; i < NUM_CHAN; i++) begin
			if (geom.w_one) begin
				pair[i] = {pix[i], 1'b0};
			end else begin
				pair[i] = {1'b0, held_q[i]} + {1'b0, pix[i]};
			end
		end
		have_pair = geom.w_one || col_q[0];
		emit_now  = have_pair && (geom.h_one || row_q[0]);
		wr_now    = have_pair && !geom.h_one && !row_q[0];
		rd_now    = have_pair && !geom.h_one && row_q[0];
		last_now  = (ox == {1'b0, geom.ow_last}) && (row_q[HEIGHT_W-1:1] == geom.oh_last);
	end

	assign ram_addr    = ADDR_W'(col_q >> 1);
	assign ram_wr_data = pair;
	assign ram_wr_en   = accept && wr_now;
	assign ram_rd_en   = accept && rd_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else if (accept) begin
			if (!geom.w_one && !col_q[0]) begin
				held_q <= pix;
			end
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= emit_now;
		end else if (ready_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit_now) begin
			ctl_s1.rd   <= rd_now;
			ctl_s1.last <= last_now;
			pair_s1     <= pair;
		end
	end
endmodule

>>> src/mlbd_back.sv
// ----------------------------------------------------------------------------
// mlbd_back
// Vertical sum, averaging, channel masking and the output register.
// ----------------------------------------------------------------------------
module mlbd_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid_s1,
	input  mlbd_pkg::ctl_t                   ctl_s1,
	input  mlbd_pkg::pair_t                  pair_s1,
	input  mlbd_pkg::pair_t                  line_data,
	input  logic [mlbd_pkg::CHAN_CNT_W-1:0]  chan_cnt,
	input  logic                             out_ready,
	output logic                             ready_s1,
	output logic                             out_valid,
	output mlbd_pkg::pix_t                   out_pix,
	output logic                             out_last
);
	import mlbd_pkg::*;

	sum_t sum;
	pix_t avg;
	logic out_valid_q;
	pix_t out_pix_q;
	logic out_last_q;

	always_comb begin
		for (int i = 0; i < NUM_CHAN; i++) begin
			if (ctl_s1.rd) begin
				sum[i] = {1'b0, line_data[i]} + {1'b0, pair_s1[i]};
			end else begin
				sum[i] = {pair_s1[i], 1'b0};
			end
			avg[i] = (CHAN_CNT_W'(i) < chan_cnt) ? sum[i][SUM_W-1:2] : '0;
		end
	end

	assign ready_s1 = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s1) begin
			out_pix_q  <= avg;
			out_last_q <= ctl_s1.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pix   = out_pix_q;
	assign out_last  = out_last_q;
endmodule

>>> src/mip_level_box_downsample_top.sv
// ----------------------------------------------------------------------------
// mip_level_box_downsample_top
// 2x2 box filter reducing one mip level to the next, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
//  Port   | Role          | Handshake        | Payload
//  src    | source pixel  | valid/ready      | chan_a, chan_b, chan_c, chan_d
//  dst    | result pixel  | valid/ready      | out_a..out_d, level_done
//  cfg_*  | register file | write enable     | cfg_index, cfg_data
//
// One item is accepted every clock while src.ready is high; a result passes
// stage one and the output register after the item that completes its 2x2 block.
// The line store holds MAX_WIDTH/2 entries of four pair sums; it is written on
// even rows and read on odd rows through one registered read port.
// Reset clears the raster position, the held pixel and the pipeline valids;
// the line store needs no clearing pass.
// A stalled result holds its register, and back-pressure reaches src.ready in
// the same cycle whenever stage one also holds an item.
// ----------------------------------------------------------------------------
module mip_level_box_downsample_top #(
	parameter int MAX_WIDTH = mlbd_pkg::MAX_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mlbd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mlbd_pkg::CFG_DATA_W-1:0]  cfg_data,
	mlbd_pix_if.sink                         src,
	mlbd_res_if.source                       dst
);
	import mlbd_pkg::*;

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	geom_t             geom;
	logic              restart;
	logic              accept;
	logic              ready_s1;
	pix_t              pix;
	logic              ram_wr_en, ram_rd_en;
	logic [ADDR_W-1:0] ram_addr;
	pair_t             ram_wr_data, ram_rd_data;
	logic              valid_s1;
	ctl_t              ctl_s1;
	pair_t             pair_s1;
	pix_t              out_pix;
	logic              out_valid, out_last;

	assign src.ready = !valid_s1 || ready_s1;
	assign accept    = src.valid && src.ready;
	assign pix       = {src.chan_d, src.chan_c, src.chan_b, src.chan_a};

	mlbd_cfg #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom),
		.restart   (restart)
	);

	mlbd_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.geom        (geom),
		.restart     (restart),
		.accept      (accept),
		.pix         (pix),
		.ready_s1    (ready_s1),
		.ram_wr_en   (ram_wr_en),
		.ram_rd_en   (ram_rd_en),
		.ram_addr    (ram_addr),
		.ram_wr_data (ram_wr_data),
		.valid_s1    (valid_s1),
		.ctl_s1      (ctl_s1),
		.pair_s1     (pair_s1)
	);

	mlbd_ram #(
		.DATA_W(LINE_W),
		.DEPTH (LINE_DEPTH)
	) u_line (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_addr),
		.rd_data (ram_rd_data)
	);

	mlbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.ctl_s1    (ctl_s1),
		.pair_s1   (pair_s1),
		.line_data (ram_rd_data),
		.chan_cnt  (geom.chan_cnt),
		.out_ready (dst.ready),
		.ready_s1  (ready_s1),
		.out_valid (out_valid),
		.out_pix   (out_pix),
		.out_last  (out_last)
	);

	assign dst.valid      = out_valid;
	assign dst.out_a      = out_pix[0];
	assign dst.out_b      = out_pix[1];
	assign dst.out_c      = out_pix[2];
	assign dst.out_d      = out_pix[3];
	assign dst.level_done = out_last;
endmodule

>>> src/mlbd_checker.sv
// ----------------------------------------------------------------------------
// mlbd_checker
// Port-level checks of the mip level box downsampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "mip_level_box_downsample_top_assert.svh"

module mlbd_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_we,
	input logic [mlbd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input logic [mlbd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [mlbd_pkg::CHAN_W-1:0]      out_a,
	input logic [mlbd_pkg::CHAN_W-1:0]      out_b,
	input logic [mlbd_pkg::CHAN_W-1:0]      out_c,
	input logic [mlbd_pkg::CHAN_W-1:0]      out_d,
	input logic                             level_done
);
	import mlbd_pkg::*;

	logic                          w_small_q;
	logic                          h_small_q;
	logic [CHAN_CNT_W-1:0]         nc_q;
	logic [NUM_CHAN*CHAN_W:0]      out_word;

	assign out_word = {level_done, out_d, out_c, out_b, out_a};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_small_q <= 1'b1;
			h_small_q <= 1'b1;
			nc_q      <= CHAN_CNT_W'(NUM_CHAN);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SOURCE_WIDTH: begin
					w_small_q <= (cfg_data[WIDTH_REG_W-1:0] <= WIDTH_REG_W'(1));
				end
				CFG_SOURCE_HEIGHT: begin
					h_small_q <= (cfg_data[HEIGHT_W-1:0] <= HEIGHT_W'(1));
				end
				CFG_CHANNEL_COUNT: begin
					nc_q <= cfg_data[CHAN_CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// A stalled result keeps its valid and its contents.
	`MLBD_ASSERT_NXT(a_result_held, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_word))

	// Channels at or above the channel count read as zero.
	`MLBD_ASSERT_IMP(a_unused_zero, clk, arst_n, out_valid, (nc_q > 3'd1 || out_b == '0) && (nc_q > 3'd2 || out_c == '0) && (nc_q > 3'd3 || out_d == '0))

	// A one by one source level gives a single pixel that closes the level.
	`MLBD_ASSERT_IMP(a_tiny_level_done, clk, arst_n, out_valid && w_small_q && h_small_q, level_done)

	// A fresh result always follows an item taken through stage one and the output register.
	`MLBD_ASSERT_IMP(a_result_latency, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2))
endmodule

bind mip_level_box_downsample_top mlbd_checker u_mlbd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_we     (cfg_we),
	.cfg_index  (cfg_index),
	.cfg_data   (cfg_data),
	.in_valid   (src.valid),
	.in_ready   (src.ready),
	.out_valid  (dst.valid),
	.out_ready  (dst.ready),
	.out_a      (dst.out_a),
	.out_b      (dst.out_b),
	.out_c      (dst.out_c),
	.out_d      (dst.out_d),
	.level_done (dst.level_done)
);
